@@ design/att_pkg.sv @@
package att_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = IDX_W + 1;
  localparam int ADDR_W        = 32;
  localparam int LEN_W         = 32;
  localparam int CTR_W         = 64;
  localparam int LOAD_LIMIT    = TABLE_ENTRIES - TABLE_ENTRIES / 4;

  localparam logic [ADDR_W-1:0] MIX_C1 = 32'h7feb352d;
  localparam logic [ADDR_W-1:0] MIX_C2 = 32'h846ca68b;
  localparam logic [CTR_W-1:0]  CTR_MAX = '1;

  typedef enum logic [1:0] {
    A_CREATE  = 2'd0,
    A_RELEASE = 2'd1,
    A_RESIZE  = 2'd2,
    A_NONE    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_UNH   = 3'd1,
    ST_FULL  = 3'd2,
    ST_UFAIL = 3'd3,
    ST_FAULT = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    F_NONE        = 4'd0,
    F_PROBE       = 4'd1,
    F_INSERT      = 4'd2,
    F_ERASE       = 4'd3,
    F_CREATE_OVF  = 4'd4,
    F_RELEASE_INV = 4'd5,
    F_RESIZE_INV  = 4'd6,
    F_FAILED_OVF  = 4'd7,
    F_DUPLICATE   = 4'd8,
    F_UNTRK_FREE  = 4'd9,
    F_UNTRK_RSZ   = 4'd10,
    F_COLLISION   = 4'd11
  } fault_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_HASH1,
    S_HASH2,
    S_HASH3,
    S_RD,
    S_CMP,
    S_RCHK,
    S_ER_RD,
    S_ER_CMP,
    S_DONE
  } state_t;

  // what a finished probe is for
  typedef enum logic [2:0] {
    J_CRE,
    J_REL,
    J_RSZ,
    J_NLK,
    J_REINS,
    J_PLACE
  } job_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] new_address;
    logic [LEN_W-1:0]  req_len;
  } in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic             healthy;
    logic [3:0]       failure_reason;
    logic [CTR_W-1:0] live_bytes;
    logic [CTR_W-1:0] peak_bytes;
    logic [CTR_W-1:0] allocated_total;
    logic [CTR_W-1:0] freed_total;
    logic [CTR_W-1:0] allocation_count;
    logic [CTR_W-1:0] release_count;
    logic [CTR_W-1:0] failed_count;
    logic [CNT_W-1:0] tracked_entries;
  } out_t;

endpackage

@@ design/att_ram.sv @@
module att_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/allocation_tracking_table.sv @@
// Flow: a request is decoded, its key hashed (S_HASH1 to S_HASH3), then slots are
//   read and compared until a match or an empty slot; an erase then walks the
//   following cluster and re-inserts each of its entries from its home slot.
// Requests are taken one at a time; the probe and re-insert loop on the shared
//   hash multiplier keeps the block busy, while a no-op or reject goes straight
//   from decode to the result.
// Reset: counters cleared, healthy set; then a pass over every entry zeroes the
//   address table before the first request is taken.
module allocation_tracking_table (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  att_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output att_pkg::out_t  out_data
);

  localparam int IW = att_pkg::IDX_W;
  localparam int AW = att_pkg::ADDR_W;
  localparam int LW = att_pkg::LEN_W;
  localparam int CW = att_pkg::CTR_W;
  localparam int NW = att_pkg::CNT_W;

  att_pkg::state_t state_r, state_nxt;
  att_pkg::job_t   job_r, job_nxt;

  // request fields
  logic [1:0]    act_r, act_nxt;
  logic [AW-1:0] key_r, key_nxt;
  logic [AW-1:0] nkey_r, nkey_nxt;
  logic [LW-1:0] len_r, len_nxt;

  // probe engine
  logic [AW-1:0] hkey_r, hkey_nxt;
  logic [AW-1:0] hv_r, hv_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] slot_r, slot_nxt;
  logic [IW-1:0] c_r, c_nxt;
  logic [IW-1:0] clr_r, clr_nxt;
  logic [LW-1:0] olen_r, olen_nxt;
  logic [AW-1:0] rkey_r, rkey_nxt;
  logic [LW-1:0] rlen_r, rlen_nxt;

  // result state
  logic [2:0]    st_r, st_nxt;
  logic          healthy_r, healthy_nxt;
  logic [3:0]    fault_r, fault_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] live_r, live_nxt;
  logic [CW-1:0] peak_r, peak_nxt;
  logic [CW-1:0] alloc_r, alloc_nxt;
  logic [CW-1:0] freed_r, freed_nxt;
  logic [CW-1:0] aev_r, aev_nxt;
  logic [CW-1:0] fev_r, fev_nxt;
  logic [CW-1:0] fail_r, fail_nxt;

  // table ports
  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [AW-1:0] wdata_a, rd_a;
  logic [LW-1:0] wdata_l, rd_l;

  att_ram #(.WIDTH(AW), .DEPTH(att_pkg::TABLE_ENTRIES)) u_addr_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata_a), .raddr(raddr), .rdata(rd_a)
  );

  att_ram #(.WIDTH(LW), .DEPTH(att_pkg::TABLE_ENTRIES)) u_len_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata_l), .raddr(raddr), .rdata(rd_l)
  );

  // shared mixer multiplier, one multiply in S_HASH1 and one in S_HASH2, kept at address width
  logic [AW-1:0] mul_a, mul_b, hsh_v, prod;

  always_comb begin
    hsh_v = {3'b000, hkey_r[AW-1:3]};
    hsh_v = hsh_v ^ (hsh_v >> 16);
    if (state_r == att_pkg::S_HASH1) begin
      mul_a = hsh_v;
      mul_b = att_pkg::MIX_C1;
    end else begin
      mul_a = hv_r ^ (hv_r >> 15);
      mul_b = att_pkg::MIX_C2;
    end
  end

  assign prod = mul_a * mul_b;

  logic [AW-1:0] hfin;
  assign hfin = hv_r ^ (hv_r >> 16);

  // decode helpers
  logic          is_noop, is_create, cmp_empty, cmp_match;
  logic [AW-1:0] ckey;
  assign is_noop   = (act_r == att_pkg::A_NONE) ||
                     (act_r == att_pkg::A_RELEASE && key_r == '0);
  assign is_create = (act_r == att_pkg::A_CREATE) ||
                     (act_r == att_pkg::A_RESIZE && key_r == '0);
  assign ckey      = (act_r == att_pkg::A_CREATE) ? key_r : nkey_r;
  assign cmp_empty = (rd_a == '0);
  assign cmp_match = (rd_a == hkey_r);

  // overflow and invariant checks
  logic [LW-1:0] o_sel;
  logic [CW:0]   live_plus_len, alloc_plus_len, freed_plus_o, freed_plus_ol, rsz_live;
  logic [CW-1:0] live_minus_o;
  logic          cre_bad, rel_bad, rsz_bad;

  assign o_sel          = (state_r == att_pkg::S_CMP) ? rd_l : olen_r;
  assign live_plus_len  = {1'b0, live_r} + {{(CW+1-LW){1'b0}}, len_r};
  assign alloc_plus_len = {1'b0, alloc_r} + {{(CW+1-LW){1'b0}}, len_r};
  assign freed_plus_o   = {1'b0, freed_r} + {{(CW+1-LW){1'b0}}, o_sel};
  assign freed_plus_ol  = {1'b0, freed_r} + {{(CW+1-LW){1'b0}}, olen_r};
  assign live_minus_o   = live_r - {{(CW-LW){1'b0}}, olen_r};
  assign rsz_live       = {1'b0, live_minus_o} + {{(CW+1-LW){1'b0}}, len_r};

  assign cre_bad = live_plus_len[CW] || alloc_plus_len[CW] || (aev_r == att_pkg::CTR_MAX);
  assign rel_bad = (live_r < {{(CW-LW){1'b0}}, o_sel}) || freed_plus_o[CW] ||
                   (freed_plus_o > {1'b0, alloc_r}) || (fev_r == att_pkg::CTR_MAX);
  assign rsz_bad = (live_r < {{(CW-LW){1'b0}}, olen_r}) || alloc_plus_len[CW] ||
                   freed_plus_ol[CW] || (aev_r == att_pkg::CTR_MAX) ||
                   (fev_r == att_pkg::CTR_MAX) || rsz_live[CW];

  logic [CW-1:0] cre_live, rsz_live_v;
  assign cre_live   = live_plus_len[CW-1:0];
  assign rsz_live_v = rsz_live[CW-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      att_pkg::S_CLEAR: begin
        if (clr_r == {IW{1'b1}}) state_nxt = att_pkg::S_IDLE;
      end
      att_pkg::S_IDLE: begin
        if (in_valid) state_nxt = att_pkg::S_DECODE;
      end
      att_pkg::S_DECODE: begin
        if (is_noop || !healthy_r) begin
          state_nxt = att_pkg::S_DONE;
        end else if (is_create) begin
          if (cre_bad || (cnt_r + 1'b1 > NW'(att_pkg::LOAD_LIMIT)) || ckey == '0) begin
            state_nxt = att_pkg::S_DONE;
          end else begin
            state_nxt = att_pkg::S_HASH1;
          end
        end else begin
          state_nxt = att_pkg::S_HASH1;
        end
      end
      att_pkg::S_HASH1: state_nxt = att_pkg::S_HASH2;
      att_pkg::S_HASH2: state_nxt = att_pkg::S_HASH3;
      att_pkg::S_HASH3: state_nxt = att_pkg::S_RD;
      att_pkg::S_RD:    state_nxt = att_pkg::S_CMP;
      att_pkg::S_CMP: begin
        if (!cmp_empty && !cmp_match) begin
          state_nxt = att_pkg::S_RD;
        end else begin
          case (job_r)
            att_pkg::J_CRE:   state_nxt = att_pkg::S_DONE;
            att_pkg::J_REL: begin
              state_nxt = (!cmp_match || rel_bad) ? att_pkg::S_DONE : att_pkg::S_ER_RD;
            end
            att_pkg::J_RSZ: begin
              if (!cmp_match || (len_r == '0 && rel_bad)) state_nxt = att_pkg::S_DONE;
              else if (len_r == '0) state_nxt = att_pkg::S_ER_RD;
              else state_nxt = att_pkg::S_RCHK;
            end
            att_pkg::J_NLK: begin
              state_nxt = cmp_match ? att_pkg::S_DONE : att_pkg::S_ER_RD;
            end
            att_pkg::J_REINS: state_nxt = att_pkg::S_ER_RD;
            att_pkg::J_PLACE: state_nxt = att_pkg::S_DONE;
            default:          state_nxt = att_pkg::S_DONE;
          endcase
        end
      end
      att_pkg::S_RCHK: begin
        if (rsz_bad || nkey_r == '0 || nkey_r == key_r) state_nxt = att_pkg::S_DONE;
        else state_nxt = att_pkg::S_HASH1;
      end
      att_pkg::S_ER_RD: state_nxt = att_pkg::S_ER_CMP;
      att_pkg::S_ER_CMP: begin
        if (cmp_empty && !(act_r == att_pkg::A_RESIZE && len_r != '0)) begin
          state_nxt = att_pkg::S_DONE;
        end else begin
          state_nxt = att_pkg::S_HASH1;
        end
      end
      att_pkg::S_DONE: begin
        if (out_ready) state_nxt = att_pkg::S_IDLE;
      end
      default: state_nxt = att_pkg::S_CLEAR;
    endcase
  end

  // datapath and table control
  always_comb begin
    job_nxt     = job_r;
    act_nxt     = act_r;
    key_nxt     = key_r;
    nkey_nxt    = nkey_r;
    len_nxt     = len_r;
    hkey_nxt    = hkey_r;
    hv_nxt      = hv_r;
    idx_nxt     = idx_r;
    slot_nxt    = slot_r;
    c_nxt       = c_r;
    clr_nxt     = clr_r;
    olen_nxt    = olen_r;
    rkey_nxt    = rkey_r;
    rlen_nxt    = rlen_r;
    st_nxt      = st_r;
    healthy_nxt = healthy_r;
    fault_nxt   = fault_r;
    cnt_nxt     = cnt_r;
    live_nxt    = live_r;
    peak_nxt    = peak_r;
    alloc_nxt   = alloc_r;
    freed_nxt   = freed_r;
    aev_nxt     = aev_r;
    fev_nxt     = fev_r;
    fail_nxt    = fail_r;
    we          = 1'b0;
    waddr       = idx_r;
    wdata_a     = '0;
    wdata_l     = len_r;
    raddr       = idx_r;

    case (state_r)
      att_pkg::S_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r;
        clr_nxt = clr_r + 1'b1;
      end
      att_pkg::S_IDLE: begin
        act_nxt  = in_data.action;
        key_nxt  = in_data.address;
        nkey_nxt = in_data.new_address;
        len_nxt  = in_data.req_len;
        st_nxt   = att_pkg::ST_OK;
      end
      att_pkg::S_DECODE: begin
        if (is_noop) begin
          st_nxt = att_pkg::ST_OK;
        end else if (!healthy_r) begin
          st_nxt = att_pkg::ST_UNH;
        end else if (is_create) begin
          if (cre_bad) begin
            healthy_nxt = 1'b0;
            fault_nxt   = att_pkg::F_CREATE_OVF;
            st_nxt      = att_pkg::ST_FAULT;
          end else if ((cnt_r + 1'b1 > NW'(att_pkg::LOAD_LIMIT)) || ckey == '0) begin
            // refused request, counted when it asked for bytes
            st_nxt = (ckey == '0 && !(cnt_r + 1'b1 > NW'(att_pkg::LOAD_LIMIT))) ?
                     att_pkg::ST_UFAIL : att_pkg::ST_FULL;
            if (len_r != '0) begin
              if (fail_r == att_pkg::CTR_MAX) begin
                healthy_nxt = 1'b0;
                fault_nxt   = att_pkg::F_FAILED_OVF;
                st_nxt      = att_pkg::ST_FAULT;
              end else begin
                fail_nxt = fail_r + 1'b1;
              end
            end
          end else begin
            hkey_nxt = ckey;
            job_nxt  = att_pkg::J_CRE;
          end
        end else if (act_r == att_pkg::A_RELEASE) begin
          hkey_nxt = key_r;
          job_nxt  = att_pkg::J_REL;
        end else begin
          hkey_nxt = key_r;
          job_nxt  = att_pkg::J_RSZ;
        end
      end
      att_pkg::S_HASH1: hv_nxt  = prod;
      att_pkg::S_HASH2: hv_nxt  = prod;
      att_pkg::S_HASH3: idx_nxt = hfin[IW-1:0];
      att_pkg::S_RD:    raddr   = idx_r;
      att_pkg::S_CMP: begin
        if (!cmp_empty && !cmp_match) begin
          idx_nxt = idx_r + 1'b1;
        end else begin
          case (job_r)
            att_pkg::J_CRE: begin
              if (cmp_match) begin
                healthy_nxt = 1'b0;
                fault_nxt   = att_pkg::F_DUPLICATE;
                st_nxt      = att_pkg::ST_FAULT;
              end else begin
                we        = 1'b1;
                waddr     = idx_r;
                wdata_a   = hkey_r;
                wdata_l   = len_r;
                cnt_nxt   = cnt_r + 1'b1;
                live_nxt  = cre_live;
                alloc_nxt = alloc_plus_len[CW-1:0];
                aev_nxt   = aev_r + 1'b1;
                peak_nxt  = (cre_live > peak_r) ? cre_live : peak_r;
                st_nxt    = att_pkg::ST_OK;
              end
            end
            att_pkg::J_REL, att_pkg::J_RSZ: begin
              olen_nxt = rd_l;
              slot_nxt = idx_r;
              if (!cmp_match) begin
                healthy_nxt = 1'b0;
                fault_nxt   = (job_r == att_pkg::J_REL) ? att_pkg::F_UNTRK_FREE :
                                                           att_pkg::F_UNTRK_RSZ;
                st_nxt      = att_pkg::ST_FAULT;
              end else if (job_r == att_pkg::J_REL || len_r == '0) begin
                if (rel_bad) begin
                  healthy_nxt = 1'b0;
                  fault_nxt   = att_pkg::F_RELEASE_INV;
                  st_nxt      = att_pkg::ST_FAULT;
                end else begin
                  // erase slot, then walk the cluster behind it
                  we      = 1'b1;
                  waddr   = idx_r;
                  wdata_a = '0;
                  cnt_nxt = cnt_r - 1'b1;
                  c_nxt   = idx_r + 1'b1;
                end
              end
            end
            att_pkg::J_NLK: begin
              if (cmp_match) begin
                healthy_nxt = 1'b0;
                fault_nxt   = att_pkg::F_COLLISION;
                st_nxt      = att_pkg::ST_FAULT;
              end else begin
                we      = 1'b1;
                waddr   = slot_r;
                wdata_a = '0;
                cnt_nxt = cnt_r - 1'b1;
                c_nxt   = slot_r + 1'b1;
              end
            end
            att_pkg::J_REINS: begin
              we      = 1'b1;
              waddr   = idx_r;
              wdata_a = rkey_r;
              wdata_l = rlen_r;
              c_nxt   = c_r + 1'b1;
            end
            att_pkg::J_PLACE: begin
              we        = 1'b1;
              waddr     = idx_r;
              wdata_a   = nkey_r;
              wdata_l   = len_r;
              cnt_nxt   = cnt_r + 1'b1;
              live_nxt  = rsz_live_v;
              alloc_nxt = alloc_plus_len[CW-1:0];
              freed_nxt = freed_plus_ol[CW-1:0];
              aev_nxt   = aev_r + 1'b1;
              fev_nxt   = fev_r + 1'b1;
              peak_nxt  = (rsz_live_v > peak_r) ? rsz_live_v : peak_r;
              st_nxt    = att_pkg::ST_OK;
            end
            default: st_nxt = st_r;
          endcase
        end
      end
      att_pkg::S_RCHK: begin
        if (rsz_bad) begin
          healthy_nxt = 1'b0;
          fault_nxt   = att_pkg::F_RESIZE_INV;
          st_nxt      = att_pkg::ST_FAULT;
        end else if (nkey_r == '0) begin
          st_nxt = att_pkg::ST_UFAIL;
          if (len_r != '0) begin
            if (fail_r == att_pkg::CTR_MAX) begin
              healthy_nxt = 1'b0;
              fault_nxt   = att_pkg::F_FAILED_OVF;
              st_nxt      = att_pkg::ST_FAULT;
            end else begin
              fail_nxt = fail_r + 1'b1;
            end
          end
        end else if (nkey_r == key_r) begin
          // same block, new length in place
          we        = 1'b1;
          waddr     = slot_r;
          wdata_a   = key_r;
          wdata_l   = len_r;
          live_nxt  = rsz_live_v;
          alloc_nxt = alloc_plus_len[CW-1:0];
          freed_nxt = freed_plus_ol[CW-1:0];
          aev_nxt   = aev_r + 1'b1;
          fev_nxt   = fev_r + 1'b1;
          peak_nxt  = (rsz_live_v > peak_r) ? rsz_live_v : peak_r;
          st_nxt    = att_pkg::ST_OK;
        end else begin
          hkey_nxt = nkey_r;
          job_nxt  = att_pkg::J_NLK;
        end
      end
      att_pkg::S_ER_RD: raddr = c_r;
      att_pkg::S_ER_CMP: begin
        if (cmp_empty) begin
          if (act_r == att_pkg::A_RESIZE && len_r != '0) begin
            hkey_nxt = nkey_r;
            job_nxt  = att_pkg::J_PLACE;
          end else begin
            live_nxt  = live_r - {{(CW-LW){1'b0}}, olen_r};
            freed_nxt = freed_plus_ol[CW-1:0];
            fev_nxt   = fev_r + 1'b1;
            st_nxt    = att_pkg::ST_OK;
          end
        end else begin
          // lift the entry out and re-insert it from its home slot
          rkey_nxt = rd_a;
          rlen_nxt = rd_l;
          hkey_nxt = rd_a;
          job_nxt  = att_pkg::J_REINS;
          we       = 1'b1;
          waddr    = c_r;
          wdata_a  = '0;
        end
      end
      att_pkg::S_DONE: begin
        st_nxt = st_r;
      end
      default: st_nxt = st_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= att_pkg::S_CLEAR;
      clr_r     <= '0;
      st_r      <= att_pkg::ST_OK;
      healthy_r <= 1'b1;
      fault_r   <= att_pkg::F_NONE;
      cnt_r     <= '0;
      live_r    <= '0;
      peak_r    <= '0;
      alloc_r   <= '0;
      freed_r   <= '0;
      aev_r     <= '0;
      fev_r     <= '0;
      fail_r    <= '0;
      job_r     <= att_pkg::J_CRE;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      st_r      <= st_nxt;
      healthy_r <= healthy_nxt;
      fault_r   <= fault_nxt;
      cnt_r     <= cnt_nxt;
      live_r    <= live_nxt;
      peak_r    <= peak_nxt;
      alloc_r   <= alloc_nxt;
      freed_r   <= freed_nxt;
      aev_r     <= aev_nxt;
      fev_r     <= fev_nxt;
      fail_r    <= fail_nxt;
      job_r     <= job_nxt;
    end
  end

  // request payload and probe registers
  always_ff @(posedge clk) begin
    act_r  <= act_nxt;
    key_r  <= key_nxt;
    nkey_r <= nkey_nxt;
    len_r  <= len_nxt;
    hkey_r <= hkey_nxt;
    hv_r   <= hv_nxt;
    idx_r  <= idx_nxt;
    slot_r <= slot_nxt;
    c_r    <= c_nxt;
    olen_r <= olen_nxt;
    rkey_r <= rkey_nxt;
    rlen_r <= rlen_nxt;
  end

  assign in_ready  = (state_r == att_pkg::S_IDLE);
  assign out_valid = (state_r == att_pkg::S_DONE);

  always_comb begin
    out_data.status           = st_r;
    out_data.healthy          = healthy_r;
    out_data.failure_reason   = fault_r;
    out_data.live_bytes       = live_r;
    out_data.peak_bytes       = peak_r;
    out_data.allocated_total  = alloc_r;
    out_data.freed_total      = freed_r;
    out_data.allocation_count = aev_r;
    out_data.release_count    = fev_r;
    out_data.failed_count     = fail_r;
    out_data.tracked_entries  = cnt_r;
  end

endmodule
